### hdl/keyed_burst_circuit_breaker_macros.svh
// assertion helpers, clocked on clk_i and disabled in reset
`ifndef KEYED_BURST_CIRCUIT_BREAKER_MACROS_SVH
`define KEYED_BURST_CIRCUIT_BREAKER_MACROS_SVH

// same-cycle implication
`define KBCB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KBCB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/kbcb_pkg.sv
package kbcb_pkg;

  localparam int FLOW_ENTRIES = 64;
  localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUIET_RESET  = 2'd2;

  typedef struct packed {
    logic start;
    logic next;
    logic take_found;
    logic take_new;
    logic eval;
    logic commit;
    logic emit_full;
  } cmd_t;

  typedef struct packed {
    logic key_match;
    logic last;
    logic empty;
    logic full;
    logic out_free;
    logic slot_new;
  } sts_t;

endpackage

### hdl/keyed_burst_circuit_breaker.sv
// Per-flow burst limiter with suppression. Each request (rule, target, time) is matched
// against a table of up to 64 flows held in a key memory with one read port, which
// compares one stored flow per cycle and stops at the first match; an empty table skips
// the search, and a new flow or a miss in a full table compares all stored flows. The
// result is held in an output register, so a new request is taken while a result still
// waits. An unknown flow is appended; when the table is full it is allowed and flagged
// table_full.
// Configuration: index 0 burst window ms, 1 burst limit, 2 quiet reset ms.
module keyed_burst_circuit_breaker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [kbcb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [87:0]                    s_axis_tdata_i,  // rule_number, target_id, time_ms
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [7:0]                     m_axis_tdata_o   // allow, newly_suppressed, table_full
);

  kbcb_pkg::cmd_t cmd;
  kbcb_pkg::sts_t sts;
  logic           allow, newly_suppressed, table_full;

  kbcb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  kbcb_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .rule_number_i      (s_axis_tdata_i[7:0]),
    .target_id_i        (s_axis_tdata_i[39:8]),
    .time_ms_i          (s_axis_tdata_i[87:40]),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_valid_o        (m_axis_tvalid_o),
    .out_ready_i        (m_axis_tready_i),
    .allow_o            (allow),
    .newly_suppressed_o (newly_suppressed),
    .table_full_o       (table_full)
  );

  assign m_axis_tdata_o = {5'd0, table_full, newly_suppressed, allow};

`include "keyed_burst_circuit_breaker_macros.svh"

  `KBCB_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "request accepted while busy")
  `KBCB_ASSERT_IMP(a_no_overwrite, cmd.commit || cmd.emit_full, sts.out_free, "pending result overwritten")
  `KBCB_ASSERT_IMP(a_append_not_full, cmd.commit && sts.slot_new, !sts.full, "flow appended to a full table")
  `KBCB_ASSERT_IMP(a_full_allows, m_axis_tvalid_o && m_axis_tdata_o[2], m_axis_tdata_o[0] && !m_axis_tdata_o[1], "table full result not a plain allow")

endmodule

### hdl/kbcb_ctrl.sv
module kbcb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  kbcb_pkg::sts_t sts_i,
  output kbcb_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_FETCH  = 3'd2;
  localparam logic [2:0] S_EVAL   = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;
  localparam logic [2:0] S_FULL   = 3'd5;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          if (sts_i.empty) begin
            cmd_o.take_new = 1'b1;
            state_d        = S_FETCH;
          end else begin
            state_d = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (sts_i.key_match) begin
          cmd_o.take_found = 1'b1;
          state_d          = S_FETCH;
        end else if (sts_i.last) begin
          if (sts_i.full) begin
            state_d = S_FULL;
          end else begin
            cmd_o.take_new = 1'b1;
            state_d        = S_FETCH;
          end
        end else begin
          cmd_o.next = 1'b1;
        end
      end
      S_FETCH: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_FULL: begin
        if (sts_i.out_free) begin
          cmd_o.emit_full = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### hdl/kbcb_datapath.sv
module kbcb_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [kbcb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic [7:0]                     rule_number_i,
  input  logic [31:0]                    target_id_i,
  input  logic [47:0]                    time_ms_i,
  input  kbcb_pkg::cmd_t                 cmd_i,
  output kbcb_pkg::sts_t                 sts_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           allow_o,
  output logic                           newly_suppressed_o,
  output logic                           table_full_o
);

  typedef struct packed {
    logic [7:0]  rule;
    logic [31:0] target;
  } key_t;

  typedef struct packed {
    logic [47:0] burst_start;
    logic [15:0] fire_cnt;
    logic [47:0] last_fire;
    logic        suppressed;
    logic        reported;
  } flow_st_t;

  function automatic logic passed(input logic [47:0] now, input logic [47:0] then,
                                  input logic [31:0] lim);
    logic [48:0] diff;
    diff = {1'b0, now} - {1'b0, then};
    return !diff[48] && (diff[47:0] > {16'd0, lim});
  endfunction

  // configuration
  logic [31:0] window_q, quiet_q;
  logic [15:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= 32'd1000;
      limit_q  <= 16'd20;
      quiet_q  <= 32'd5000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kbcb_pkg::CFG_BURST_WINDOW: window_q <= cfg_data_i;
        kbcb_pkg::CFG_BURST_LIMIT:  limit_q  <= cfg_data_i[15:0];
        kbcb_pkg::CFG_QUIET_RESET:  quiet_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // request
  key_t        key_q;
  logic [47:0] now_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q <= '{rule: rule_number_i, target: target_id_i};
      now_q <= time_ms_i;
    end
  end

  // search index and flow count
  logic [kbcb_pkg::IDX_W-1:0] idx_q, idx_d, slot_q;
  logic [kbcb_pkg::CNT_W-1:0] count_q;
  logic                       new_q;

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.start) begin
      idx_d = '0;
    end else if (cmd_i.next) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      slot_q  <= '0;
      new_q   <= 1'b0;
      count_q <= '0;
    end else begin
      idx_q <= idx_d;
      if (cmd_i.take_found) begin
        slot_q <= idx_q;
        new_q  <= 1'b0;
      end else if (cmd_i.take_new) begin
        slot_q <= count_q[kbcb_pkg::IDX_W-1:0];
        new_q  <= 1'b1;
      end
      if (cmd_i.commit && new_q) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  // flow memories
  key_t     key_mem [kbcb_pkg::FLOW_ENTRIES];
  flow_st_t st_mem  [kbcb_pkg::FLOW_ENTRIES];
  key_t     key_rd_q;
  flow_st_t st_rd_q;

  // evaluation
  flow_st_t    st_cur, st_nxt;
  logic        q_pass_q, w_pass_q;
  logic        blocked, restart, over;
  logic [15:0] cnt0, cnt1;
  logic        rep0;

  always_comb begin
    if (new_q) begin
      st_cur = '{burst_start: now_q, fire_cnt: 16'd0, last_fire: 48'd0,
                 suppressed: 1'b0, reported: 1'b0};
    end else begin
      st_cur = st_rd_q;
    end
    blocked = st_cur.suppressed && !q_pass_q;
    restart = st_cur.suppressed || w_pass_q;
    cnt0    = restart ? 16'd0 : st_cur.fire_cnt;
    cnt1    = (cnt0 == 16'hFFFF) ? cnt0 : cnt0 + 16'd1;
    rep0    = st_cur.suppressed ? 1'b0 : st_cur.reported;
    over    = cnt1 > limit_q;
    st_nxt  = '{burst_start: restart ? now_q : st_cur.burst_start,
                fire_cnt: cnt1, last_fire: now_q,
                suppressed: over, reported: rep0 | over};
  end

  always_ff @(posedge clk_i) begin
    key_rd_q <= key_mem[idx_d];
    st_rd_q  <= st_mem[slot_q];
    if (cmd_i.commit && new_q) begin
      key_mem[slot_q] <= key_q;
    end
    if (cmd_i.commit && !blocked) begin
      st_mem[slot_q] <= st_nxt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      q_pass_q <= passed(now_q, st_cur.last_fire, quiet_q);
      w_pass_q <= passed(now_q, st_cur.burst_start, window_q);
    end
  end

  // result register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit || cmd_i.emit_full) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      allow_o            <= !blocked && !over;
      newly_suppressed_o <= !blocked && over && !rep0;
      table_full_o       <= 1'b0;
    end else if (cmd_i.emit_full) begin
      allow_o            <= 1'b1;
      newly_suppressed_o <= 1'b0;
      table_full_o       <= 1'b1;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.key_match = (key_rd_q == key_q);
  assign sts_o.last      = ({{(kbcb_pkg::CNT_W - kbcb_pkg::IDX_W){1'b0}}, idx_q} + 1'b1)
                           == count_q;
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.full      = (count_q == kbcb_pkg::CNT_W'(kbcb_pkg::FLOW_ENTRIES));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.slot_new  = new_q;

endmodule
